### src/ctrdrbg_pkg.sv
// Shared types, constants and AES helper functions for the counter-mode DRBG generator.
// No dependencies; used by the round unit and the top level.
package ctrdrbg_pkg;

	localparam int MAX_REQUEST_BLOCKS = 4096;
	localparam int BIR_W              = 13;
	localparam int COUNT_W            = 48;
	localparam int ROUNDS             = 14;
	localparam int RND_W              = 4;
	localparam int UPD_BLOCKS         = 3;
	localparam int BLK_W              = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_FIN
	} state_t;

	// Command codes
	localparam logic CMD_INST = 1'b0;
	localparam logic CMD_GEN  = 1'b1;

	// Key schedule control carried into the round unit
	typedef struct packed {
		logic [7:0] rcon;     // current round constant
		logic       even;     // next expansion step is a rot/sub/rcon step
		logic       last;     // final round, no column mixing
	} ks_ctl_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// S-box on each byte of a 32-bit word
	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

### src/ctrdrbg_round.sv
// One AES-256 round plus one on-the-fly key expansion step (four words).
// Depends on ctrdrbg_pkg.
module ctrdrbg_round (
	input  logic [127:0]             state_in,
	input  logic [255:0]             window_in,
	input  ctrdrbg_pkg::ks_ctl_t     ctl,
	output logic [127:0]             state_out,
	output logic [255:0]             window_out,
	output logic [7:0]               rcon_out
);
	import ctrdrbg_pkg::*;

	logic [7:0]  sb  [16];
	logic [7:0]  sr  [16];
	logic [7:0]  mc  [16];
	logic [31:0] wd  [8];
	logic [31:0] nw  [4];
	logic [31:0] t;

	// SubBytes, ShiftRows, MixColumns, AddRoundKey
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sb[i] = SBOX[state_in[127-8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[r+4*c] = sb[r + 4*((c+r) % 4)];
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] all;
			all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
			if (ctl.last) begin
				for (int r = 0; r < 4; r++) begin
					mc[4*c+r] = sr[4*c+r];
				end
			end else begin
				mc[4*c]   = sr[4*c]   ^ all ^ xtime(sr[4*c]   ^ sr[4*c+1]);
				mc[4*c+1] = sr[4*c+1] ^ all ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
				mc[4*c+2] = sr[4*c+2] ^ all ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
				mc[4*c+3] = sr[4*c+3] ^ all ^ xtime(sr[4*c+3] ^ sr[4*c]);
			end
		end
		for (int i = 0; i < 16; i++) begin
			state_out[127-8*i -: 8] = mc[i] ^ window_in[127-8*i -: 8];
		end
	end

	// Key expansion: slide the eight-word window by four words
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			wd[j] = window_in[255-32*j -: 32];
		end
		if (ctl.even) begin
			t = sub_word({wd[7][23:0], wd[7][31:24]}) ^ {ctl.rcon, 24'h0};
		end else begin
			t = sub_word(wd[7]);
		end
		nw[0] = wd[0] ^ t;
		nw[1] = wd[1] ^ nw[0];
		nw[2] = wd[2] ^ nw[1];
		nw[3] = wd[3] ^ nw[2];
		window_out = {wd[4], wd[5], wd[6], wd[7], nw[0], nw[1], nw[2], nw[3]};
		rcon_out   = ctl.even ? xtime(ctl.rcon) : ctl.rcon;
	end

endmodule

### src/ctr_drbg_aes256_generator.sv
// Counter-mode DRBG (AES-256, no derivation function) generator top level.
// Depends on ctrdrbg_pkg and ctrdrbg_round.
//
// The input is stalled from the cycle after an item is accepted until the
// item is done. One AES-256 block runs fourteen rounds on the shared round
// unit, one round per cycle, with the key schedule expanded on the fly
// alongside; the counter and whitening key are loaded in the accept cycle. A
// generate item passes through the accept cycle, the fourteen rounds and the
// ST_FIN state, which moves the block into the output register. A generate
// item that closes a request runs three more blocks for the update; an
// instantiate item runs the three update blocks and gives no result. A block
// refused for a too-long request that does not close it goes straight to the
// output register. A finished result waits in the output register while the
// output is stalled; the next item is taken while it waits, and that item's
// own result waits until the register is free.
module ctr_drbg_aes256_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [63:0]                   seed_word_0,
	input  logic [63:0]                   seed_word_1,
	input  logic [63:0]                   seed_word_2,
	input  logic [63:0]                   seed_word_3,
	input  logic [63:0]                   seed_word_4,
	input  logic [63:0]                   seed_word_5,
	input  logic                          request_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [63:0]                   block_high,
	output logic [63:0]                   block_low,
	output logic                          last_of_request,
	output logic                          status,
	output logic [ctrdrbg_pkg::COUNT_W-1:0] requests_done
);
	import ctrdrbg_pkg::*;

	state_t               state_q, state_d;
	logic [255:0]         key_q;
	logic [127:0]         ctr_q;
	logic [COUNT_W-1:0]   req_q;
	logic [BIR_W-1:0]     bir_q;
	logic [383:0]         data_q;
	logic [255:0]         tmp_q;
	logic [127:0]         s_q;
	logic [255:0]         w_q;
	logic [7:0]           rc_q;
	logic                 kev_q;
	logic [RND_W-1:0]     rnd_q;
	logic                 upd_q;
	logic [BLK_W-1:0]     blk_q;
	logic                 inst_q;
	logic                 end_q;
	logic                 held_q;
	logic [127:0]         res_q;
	logic                 out_valid_q;

	logic                 acc;
	logic                 over;
	logic                 out_free;
	logic                 enc_done;
	logic                 upd_last;
	logic [127:0]         inc;
	ks_ctl_t              ctl;
	logic [127:0]         s_nxt;
	logic [255:0]         w_nxt;
	logic [7:0]           rc_nxt;

	// Handshake and status terms
	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign over     = (bir_q >= BIR_W'(MAX_REQUEST_BLOCKS));
	assign out_free = !out_valid_q || !out_stall;
	assign enc_done = (state_q == ST_ENC) && (rnd_q == RND_W'(ROUNDS));
	assign upd_last = upd_q && (blk_q == BLK_W'(UPD_BLOCKS - 1));
	assign inc      = ctr_q + 128'd1;

	// Shared round unit
	assign ctl.rcon = rc_q;
	assign ctl.even = kev_q;
	assign ctl.last = (rnd_q == RND_W'(ROUNDS));

	ctrdrbg_round u_round (
		.state_in   (s_q),
		.window_in  (w_q),
		.ctl        (ctl),
		.state_out  (s_nxt),
		.window_out (w_nxt),
		.rcon_out   (rc_nxt)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cmd == CMD_INST || !over || request_end) begin
						state_d = ST_ENC;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_ENC: begin
				if (enc_done) begin
					if (upd_last) begin
						state_d = inst_q ? ST_IDLE : ST_FIN;
					end else if (upd_q || end_q) begin
						state_d = ST_ENC;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// DRBG state, sequencing and round datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			ctr_q  <= '0;
			req_q  <= '0;
			bir_q  <= '0;
			data_q <= '0;
			tmp_q  <= '0;
			s_q    <= '0;
			w_q    <= '0;
			res_q  <= '0;
			rnd_q  <= '0;
			upd_q  <= 1'b0;
			blk_q  <= '0;
			inst_q <= 1'b0;
			end_q  <= 1'b0;
			held_q <= 1'b0;
			kev_q  <= 1'b1;
			rc_q   <= 8'h01;
		end else if (acc) begin
			inst_q <= (cmd == CMD_INST);
			end_q  <= request_end;
			blk_q  <= '0;
			rnd_q  <= RND_W'(1);
			rc_q   <= 8'h01;
			kev_q  <= 1'b1;
			if (cmd == CMD_INST) begin
				// Zero key and counter; the first update block uses counter one
				key_q  <= '0;
				ctr_q  <= 128'd1;
				s_q    <= 128'd1;
				w_q    <= '0;
				upd_q  <= 1'b1;
				held_q <= 1'b0;
				data_q <= {seed_word_0, seed_word_1, seed_word_2,
					seed_word_3, seed_word_4, seed_word_5};
			end else begin
				data_q <= '0;
				s_q    <= inc ^ key_q[255:128];
				w_q    <= key_q;
				if (!over) begin
					ctr_q  <= inc;
					upd_q  <= 1'b0;
					held_q <= 1'b0;
					bir_q  <= bir_q + BIR_W'(1);
				end else begin
					// Block withheld; the counter moves only for a closing update
					held_q <= 1'b1;
					upd_q  <= 1'b1;
					if (request_end) begin
						ctr_q <= inc;
					end
				end
			end
		end else if (state_q == ST_ENC) begin
			if (!enc_done) begin
				s_q   <= s_nxt;
				w_q   <= w_nxt;
				rc_q  <= rc_nxt;
				kev_q <= !kev_q;
				rnd_q <= rnd_q + RND_W'(1);
			end else begin
				// Block finished: restart the unit on the next counter
				s_q   <= inc ^ key_q[255:128];
				w_q   <= key_q;
				rc_q  <= 8'h01;
				kev_q <= 1'b1;
				rnd_q <= RND_W'(1);
				if (!upd_q) begin
					res_q <= s_nxt;
					upd_q <= 1'b1;
					blk_q <= '0;
					// only a closing update uses the next counter
					if (end_q) begin
						ctr_q <= inc;
					end
				end else if (!upd_last) begin
					if (blk_q == '0) begin
						tmp_q[255:128] <= s_nxt;
					end else begin
						tmp_q[127:0] <= s_nxt;
					end
					blk_q <= blk_q + BLK_W'(1);
					ctr_q <= inc;
				end else begin
					// Third block: new key and counter
					key_q <= tmp_q ^ data_q[383:128];
					ctr_q <= s_nxt ^ data_q[127:0];
					bir_q <= '0;
					if (inst_q) begin
						req_q <= COUNT_W'(1);
					end else if (req_q != COUNT_MAX) begin
						req_q <= req_q + COUNT_W'(1);
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			block_high      <= held_q ? 64'd0 : res_q[127:64];
			block_low       <= held_q ? 64'd0 : res_q[63:0];
			last_of_request <= end_q;
			status          <= held_q;
			requests_done   <= req_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### src/ctrdrbg_checker.sv
// Port-level checker for the counter-mode DRBG generator, bound to the top level.
// Depends on ctr_drbg_aes256_generator.
module ctrdrbg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] block_high,
	input logic [63:0] block_low,
	input logic        status
);

	// A waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A withheld block reads as zero
	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (block_high == 64'd0) && (block_low == 64'd0))
		else $error("withheld block not zero");

	// Accepting an item makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

endmodule

bind ctr_drbg_aes256_generator ctrdrbg_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.block_high (block_high),
	.block_low  (block_low),
	.status     (status)
);

### test/tb.sv
// Self-checking bench for ctr_drbg_aes256_generator: an AES-256 counter-mode
// DRBG predictor in a small scoreboard class, bursty input and random output stall.
// Depends on ctrdrbg_pkg and the generator RTL.
`timescale 1ns / 100ps

module tb;
	import ctrdrbg_pkg::*;

	localparam int LIMIT_BLOCKS = 4096;

	localparam logic [7:0] AES_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	typedef struct {
		logic [63:0]        hi;
		logic [63:0]        lo;
		logic               last;
		logic               st;
		logic [COUNT_W-1:0] reqs;
	} drbg_block_t;

	// DRBG state mirror and queue of blocks still owed by the generator
	class drbg_scoreboard;
		logic [255:0]       key;
		logic [127:0]       ctr;
		logic [COUNT_W-1:0] reqs;
		int                 blocks_open;
		drbg_block_t        owed[$];
		int                 errors;

		function new();
			key = '0;
			ctr = '0;
			reqs = '0;
			blocks_open = 0;
			errors = 0;
		endfunction

		function logic [7:0] dbl(logic [7:0] a);
			return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		endfunction

		// Full AES-256 key schedule, 240 bytes
		function void schedule(output logic [7:0] ks [240]);
			logic [7:0] t [4];
			logic [7:0] rc, tmp;
			rc = 8'h01;
			for (int i = 0; i < 32; i++)
				ks[i] = key[255 - 8*i -: 8];
			for (int i = 8; i < 60; i++) begin
				for (int j = 0; j < 4; j++)
					t[j] = ks[4*(i-1) + j];
				if ((i & 7) == 0) begin
					tmp = t[0];
					t[0] = AES_SBOX[t[1]] ^ rc;
					t[1] = AES_SBOX[t[2]];
					t[2] = AES_SBOX[t[3]];
					t[3] = AES_SBOX[tmp];
					rc = dbl(rc);
				end else if ((i & 7) == 4) begin
					for (int j = 0; j < 4; j++)
						t[j] = AES_SBOX[t[j]];
				end
				for (int j = 0; j < 4; j++)
					ks[4*i + j] = ks[4*(i-8) + j] ^ t[j];
			end
		endfunction

		function logic [127:0] encrypt(input logic [7:0] ks [240], input logic [127:0] pt);
			logic [7:0]   s [16];
			logic [7:0]   o [16];
			logic [7:0]   a0, a1, a2, a3, all;
			logic [127:0] r;
			for (int i = 0; i < 16; i++)
				s[i] = pt[127 - 8*i -: 8] ^ ks[i];
			for (int rnd = 1; rnd <= 14; rnd++) begin
				for (int i = 0; i < 16; i++)
					o[i] = AES_SBOX[s[i]];
				for (int c = 0; c < 4; c++)
					for (int rw = 0; rw < 4; rw++)
						s[rw + 4*c] = o[rw + 4*((c + rw) & 3)];
				if (rnd != 14) begin
					for (int c = 0; c < 4; c++) begin
						a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
						all = a0 ^ a1 ^ a2 ^ a3;
						s[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
						s[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
						s[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
						s[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
					end
				end
				for (int i = 0; i < 16; i++)
					s[i] ^= ks[16*rnd + i];
			end
			for (int i = 0; i < 16; i++)
				r[127 - 8*i -: 8] = s[i];
			return r;
		endfunction

		// Three counter blocks XORed with provided data become key and counter
		function void reseed_mix(logic [383:0] data);
			logic [7:0]   ks [240];
			logic [383:0] tmp;
			schedule(ks);
			for (int b = 0; b < 3; b++) begin
				ctr = ctr + 128'd1;
				tmp[383 - 128*b -: 128] = encrypt(ks, ctr);
			end
			tmp ^= data;
			key = tmp[383:128];
			ctr = tmp[127:0];
		endfunction

		function void note_input(logic c, logic [383:0] seed, logic req_end);
			logic [7:0]  ks [240];
			logic [127:0] blk;
			drbg_block_t e;
			if (c == CMD_INST) begin
				key = '0;
				ctr = '0;
				reseed_mix(seed);
				reqs = COUNT_W'(1);
				blocks_open = 0;
				return;
			end
			e.hi = '0;
			e.lo = '0;
			e.st = 1'b0;
			if (blocks_open >= LIMIT_BLOCKS) begin
				e.st = 1'b1;
			end else begin
				schedule(ks);
				ctr = ctr + 128'd1;
				blk = encrypt(ks, ctr);
				e.hi = blk[127:64];
				e.lo = blk[63:0];
				blocks_open++;
			end
			if (req_end) begin
				reseed_mix('0);
				if (reqs != COUNT_MAX)
					reqs++;
				blocks_open = 0;
			end
			e.last = req_end;
			e.reqs = reqs;
			owed.push_back(e);
		endfunction

		function void check(drbg_block_t got);
			drbg_block_t e;
			if (owed.size() == 0) begin
				$error("unexpected block %h_%h", got.hi, got.lo);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.hi !== e.hi) begin
				$error("block_high exp %h got %h", e.hi, got.hi); errors++;
			end
			if (got.lo !== e.lo) begin
				$error("block_low exp %h got %h", e.lo, got.lo); errors++;
			end
			if (got.last !== e.last) begin
				$error("last_of_request exp %b got %b", e.last, got.last); errors++;
			end
			if (got.st !== e.st) begin
				$error("status exp %b got %b", e.st, got.st); errors++;
			end
			if (got.reqs !== e.reqs) begin
				$error("requests_done exp %h got %h", e.reqs, got.reqs); errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = 1'b0;
	logic [63:0]        seed_word_0 = '0, seed_word_1 = '0, seed_word_2 = '0;
	logic [63:0]        seed_word_3 = '0, seed_word_4 = '0, seed_word_5 = '0;
	logic               request_end = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [63:0]        block_high, block_low;
	logic               last_of_request, status;
	logic [COUNT_W-1:0] requests_done;

	drbg_scoreboard sb = new();
	int burst_left = 0;
	int stall_pct = 0;
	int stall_phase = 0;

	always #2 clk = ~clk;

	ctr_drbg_aes256_generator dut (.*);

	// Receiver: stall density is redrawn each time stall_phase wraps to zero, some stretches free
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 30;
				2: stall_pct <= 60;
				default: stall_pct <= 90;
			endcase
		end
		stall_phase <= (stall_phase + 1) % 64;
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		drbg_block_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.hi = block_high;
			got.lo = block_low;
			got.last = last_of_request;
			got.st = status;
			got.reqs = requests_done;
			sb.check(got);
		end
	end

	function automatic logic [383:0] rand_seed();
		logic [383:0] s;
		for (int i = 0; i < 12; i++)
			s[32*i +: 32] = $urandom;
		return s;
	endfunction

	// Sender: bursts of items with random gaps between them
	task automatic send_item(logic c, logic [383:0] seed, logic req_end);
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		cmd <= c;
		{seed_word_0, seed_word_1, seed_word_2, seed_word_3, seed_word_4, seed_word_5} <= seed;
		request_end <= req_end;
		do @(posedge clk); while (in_stall);
		sb.note_input(c, seed, req_end);
		burst_left--;
	endtask

	initial begin
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: generate on reset state, seed extremes, one-block requests
		send_item(CMD_GEN, '0, 1'b0);
		send_item(CMD_GEN, '1, 1'b1);
		send_item(CMD_INST, '0, 1'b0);
		send_item(CMD_GEN, '1, 1'b1);
		send_item(CMD_INST, '1, 1'b1);
		send_item(CMD_GEN, '0, 1'b0);
		send_item(CMD_GEN, '0, 1'b0);
		send_item(CMD_GEN, '0, 1'b1);
		send_item(CMD_INST, {96{4'hA}}, 1'b0);
		send_item(CMD_GEN, {96{4'h5}}, 1'b1);
		send_item(CMD_INST, {96{4'h5}}, 1'b1);
		send_item(CMD_GEN, rand_seed(), 1'b1);

		// Random: mostly well-formed requests, some reseeds and broken ones
		for (int n = 0; n < 1290; ) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(CMD_INST, rand_seed(), 1'($urandom_range(0, 1)));
				n++;
			end
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					// request cut short by an instantiate
					send_item(CMD_INST, rand_seed(), 1'($urandom_range(0, 1)));
					n++;
					break;
				end
				send_item(CMD_GEN, rand_seed(),
					(i == len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0));
				n++;
			end
		end

		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("[ctr_drbg_aes256_generator] OK");
		else
			$display("[ctr_drbg_aes256_generator] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("[ctr_drbg_aes256_generator] ERROR");
		$finish;
	end

endmodule
